// ===== hdl/salc_pkg.sv =====
// Shared types, constants and defaults for the set-associative LRU cache controller.
package salc_pkg;

	// Default sizing for the top-level parameters
	localparam int MAX_WAYS_DEF  = 16;
	localparam int MAX_SETS_DEF  = 1024;
	localparam int ADDR_BITS_DEF = 32;

	// Fixed field widths
	localparam int TAG_W   = 30;
	localparam int AGE_W   = 4;
	localparam int CNT_W   = 40;
	localparam int BYTE_W  = 48;
	localparam int CFG_W   = 5;
	localparam int OUT_W   = 224;
	localparam logic [AGE_W-1:0] AGE_MAX = 4'd15;

	// Decoupling queue depth between front and back
	localparam int QD   = 2;
	localparam int QP_W = 1;
	localparam int QC_W = 2;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_BLOCK_SHIFT = 2'd0,
		CFG_SET_SHIFT   = 2'd1,
		CFG_WAYS_USED   = 2'd2,
		CFG_WRITE_BACK  = 2'd3
	} cfg_reg_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EVAL
	} back_state_t;

	// One stored line of a set row
	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [AGE_W-1:0] age;
		logic [TAG_W-1:0] tag;
	} line_t;

	localparam int LINE_W = $bits(line_t);

	// Classified access handed from front to back
	typedef struct packed {
		logic             write_op;
		logic             wb;
		logic [3:0]       bs;
		logic [TAG_W-1:0] tag;
	} req_info_t;

endpackage

// ===== hdl/salc_front.sv =====
// Front end: configuration registers, address split and the decoupling queue.
module salc_front
	import salc_pkg::*;
#(
	parameter int MAX_WAYS  = MAX_WAYS_DEF,
	parameter int MAX_SETS  = MAX_SETS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF,
	localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,
	input  logic                s_tuser,
	input  logic                clearing,
	input  logic                q_pop,
	output logic                q_valid,
	output req_info_t           q_info,
	output logic [SET_W-1:0]    q_set,
	output logic [MAX_WAYS-1:0] q_mask
);

	localparam int SS_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

	logic [3:0] block_shift_q;
	logic [3:0] set_shift_q;
	logic [4:0] ways_used_q;
	logic       write_back_q;

	logic [3:0]          bs_c;
	logic [3:0]          ss_c;
	logic [31:0]         addr_m;
	logic [31:0]         blk;
	logic [31:0]         set_all;
	logic [31:0]         tag_all;
	logic [MAX_WAYS-1:0] mask_c;
	int                  ways_c;

	req_info_t           qi_q   [QD];
	logic [SET_W-1:0]    qs_q   [QD];
	logic [MAX_WAYS-1:0] qm_q   [QD];
	logic [QP_W-1:0]     wptr_q;
	logic [QP_W-1:0]     rptr_q;
	logic [QC_W-1:0]     cnt_q;
	logic                push;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_shift_q <= 4'd2;
			set_shift_q   <= 4'd0;
			ways_used_q   <= 5'd1;
			write_back_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BLOCK_SHIFT: block_shift_q <= cfg_data[3:0];
				CFG_SET_SHIFT:   set_shift_q   <= cfg_data[3:0];
				CFG_WAYS_USED:   ways_used_q   <= cfg_data;
				CFG_WRITE_BACK:  write_back_q  <= cfg_data[0];
			endcase
		end
	end

	// Clamp the sizes and split the address into set and tag
	always_comb begin
		if (block_shift_q < 4'd2)      bs_c = 4'd2;
		else if (block_shift_q > 4'd8) bs_c = 4'd8;
		else                           bs_c = block_shift_q;
		if (int'(set_shift_q) > SS_MAX) ss_c = 4'(SS_MAX);
		else                            ss_c = set_shift_q;
		addr_m  = s_tdata & ADDR_MASK;
		blk     = addr_m >> bs_c;
		set_all = blk & ((32'd1 << ss_c) - 32'd1);
		tag_all = blk >> ss_c;
		ways_c  = (ways_used_q == 5'd0) ? 1 : int'(ways_used_q);
		for (int w = 0; w < MAX_WAYS; w++) begin
			mask_c[w] = (w < ways_c);
		end
	end

	// Two-entry queue towards the back end
	assign s_tready = !clearing && (cnt_q != QC_W'(QD));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != '0);
	assign q_info   = qi_q[rptr_q];
	assign q_set    = qs_q[rptr_q];
	assign q_mask   = qm_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			qi_q[wptr_q] <= '{write_op: s_tuser, wb: write_back_q, bs: bs_c,
				tag: tag_all[TAG_W-1:0]};
			qs_q[wptr_q] <= set_all[SET_W-1:0];
			qm_q[wptr_q] <= mask_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)  wptr_q <= wptr_q + 1'b1;
			if (q_pop) rptr_q <= rptr_q + 1'b1;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/salc_back.sv =====
// Back end: set memory, hit and victim logic, LRU ranks, counters and result register.
module salc_back
	import salc_pkg::*;
#(
	parameter int MAX_WAYS = MAX_WAYS_DEF,
	parameter int MAX_SETS = MAX_SETS_DEF,
	localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  req_info_t           q_info,
	input  logic [SET_W-1:0]    q_set,
	input  logic [MAX_WAYS-1:0] q_mask,
	output logic                q_pop,
	output logic                clearing,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata
);

	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int ROW_W = MAX_WAYS * LINE_W;

	back_state_t state_q, state_d;
	logic [SET_W-1:0] clr_idx_q;

	logic [ROW_W-1:0] mem [MAX_SETS];
	logic [ROW_W-1:0] rd_q;
	logic [ROW_W-1:0] wr_row;
	logic             rd_en;
	logic             mem_we;
	logic [SET_W-1:0] wa;
	logic             done;

	line_t               lines [MAX_WAYS];
	line_t               nl;
	logic [MAX_WAYS-1:0] match, inval, cand, tb;
	logic                hit, any_inv, evd, wt, wr_add;
	logic [WAY_W-1:0]    hw, iw, lw, victim;
	logic [AGE_W:0]      old;

	logic [CNT_W-1:0]  req_q, hits_q, miss_q;
	logic [BYTE_W-1:0] fetch_q, wrb_q;
	logic [CNT_W-1:0]  req_d, hits_d, miss_d;
	logic [BYTE_W-1:0] fetch_d, wrb_d, bsize;
	logic [BYTE_W:0]   fsum, wsum;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  m_tdata_q;

	assign clearing = (state_q == BK_CLEAR);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		done    = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_idx_q == SET_W'(MAX_SETS - 1)) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (q_valid) begin
					rd_en   = 1'b1;
					state_d = BK_EVAL;
				end
			end
			BK_EVAL: begin
				if (!m_tvalid_q || m_tready) begin
					done    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	assign q_pop  = done;
	assign mem_we = clearing || done;
	assign wa     = clearing ? clr_idx_q : q_set;

	// Set row memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[wa] <= clearing ? '0 : wr_row;
		if (rd_en)  rd_q <= mem[q_set];
	end

	// Hit search, first free way and LRU victim
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			lines[w] = rd_q[w*LINE_W +: LINE_W];
			match[w] = q_mask[w] && lines[w].valid && (lines[w].tag == q_info.tag);
			inval[w] = q_mask[w] && !lines[w].valid;
		end
		hit     = |match;
		any_inv = |inval;
		// narrow the candidates to the highest age, one age bit a step
		cand = q_mask;
		for (int b = AGE_W - 1; b >= 0; b--) begin
			for (int w = 0; w < MAX_WAYS; w++) begin
				tb[w] = cand[w] && lines[w].age[b];
			end
			if (tb != '0) cand = tb;
		end
		hw = '0;
		iw = '0;
		lw = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) hw = WAY_W'(w);
			if (inval[w]) iw = WAY_W'(w);
			if (cand[w])  lw = WAY_W'(w);
		end
		if (hit) begin
			victim = hw;
			old    = {1'b0, lines[hw].age};
		end else if (any_inv) begin
			victim = iw;
			old    = {1'b0, AGE_MAX} + 1'b1;
		end else begin
			victim = lw;
			old    = {1'b0, lines[lw].age};
		end
		evd    = !hit && !any_inv && lines[lw].dirty && q_info.wb;
		wt     = q_info.write_op && !q_info.wb;
		wr_add = evd || wt;
	end

	// New set row
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			nl = lines[w];
			if (WAY_W'(w) == victim) begin
				nl.age = '0;
				if (!hit) begin
					nl.valid = 1'b1;
					nl.tag   = q_info.tag;
					nl.dirty = q_info.write_op && q_info.wb;
				end else if (q_info.write_op && q_info.wb) begin
					nl.dirty = 1'b1;
				end
			end else if (q_mask[w] && lines[w].valid && ({1'b0, lines[w].age} < old)
					&& (lines[w].age != AGE_MAX)) begin
				nl.age = lines[w].age + 1'b1;
			end
			wr_row[w*LINE_W +: LINE_W] = nl;
		end
	end

	// Saturating counters
	always_comb begin
		bsize   = BYTE_W'(1) << q_info.bs;
		req_d   = (req_q == '1) ? req_q : req_q + 1'b1;
		hits_d  = hits_q;
		miss_d  = miss_q;
		fetch_d = fetch_q;
		wrb_d   = wrb_q;
		fsum    = {1'b0, fetch_q} + {1'b0, bsize};
		wsum    = {1'b0, wrb_q} + {1'b0, bsize};
		if (hit) begin
			hits_d = (hits_q == '1) ? hits_q : hits_q + 1'b1;
		end else begin
			miss_d  = (miss_q == '1) ? miss_q : miss_q + 1'b1;
			fetch_d = fsum[BYTE_W] ? '1 : fsum[BYTE_W-1:0];
		end
		if (wr_add) wrb_d = wsum[BYTE_W] ? '1 : wsum[BYTE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q   <= '0;
			hits_q  <= '0;
			miss_q  <= '0;
			fetch_q <= '0;
			wrb_q   <= '0;
		end else if (done) begin
			req_q   <= req_d;
			hits_q  <= hits_d;
			miss_q  <= miss_d;
			fetch_q <= fetch_d;
			wrb_q   <= wrb_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata_q <= {5'd0, wrb_d, fetch_d, miss_d, hits_d, req_d, wt, evd, hit};
		end
	end

endmodule

// ===== hdl/set_assoc_lru_cache_controller.sv =====
// Set-associative LRU cache controller top level: front, queue and back wired up.
// An access goes through BK_IDLE, reading the set row from the single-port set
// memory, then BK_EVAL, evaluating hit, victim and LRU ranks and writing the row back
// once no untaken result is held; only then is the next item read. A two-item queue
// lets the front keep taking items while the back works, and a result register holds
// each finished item until m_tready takes it. After reset the back end clears all
// MAX_SETS rows of the set memory (1024 by default), one row a cycle; s_tready stays
// low during that pass while configuration writes are still taken.
module set_assoc_lru_cache_controller
	import salc_pkg::*;
#(
	parameter int MAX_WAYS  = MAX_WAYS_DEF,
	parameter int MAX_SETS  = MAX_SETS_DEF,
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // address
	input  logic             s_tuser,   // access kind: 0 read, 1 write
	output logic             m_tvalid,
	input  logic             m_tready,
	// hit, evicted_dirty, wrote_through, request_count, hit_count, miss_count,
	// bytes_fetched, bytes_written, zero fill
	output logic [OUT_W-1:0] m_tdata
);

	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

	logic                clearing;
	logic                q_pop;
	logic                q_valid;
	req_info_t           q_info;
	logic [SET_W-1:0]    q_set;
	logic [MAX_WAYS-1:0] q_mask;

	salc_front #(
		.MAX_WAYS(MAX_WAYS),
		.MAX_SETS(MAX_SETS),
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.clearing(clearing),
		.q_pop(q_pop),
		.q_valid(q_valid),
		.q_info(q_info),
		.q_set(q_set),
		.q_mask(q_mask)
	);

	salc_back #(
		.MAX_WAYS(MAX_WAYS),
		.MAX_SETS(MAX_SETS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_info(q_info),
		.q_set(q_set),
		.q_mask(q_mask),
		.q_pop(q_pop),
		.clearing(clearing),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule

// ===== hdl/salc_checker.sv =====
// Port-level checks on the cache controller results, bound to the top level.
module salc_checker
	import salc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	logic             r_hit, r_evd, r_wt;
	logic [CNT_W-1:0] r_req, r_hits, r_miss;

	assign r_hit  = m_tdata[0];
	assign r_evd  = m_tdata[1];
	assign r_wt   = m_tdata[2];
	assign r_req  = m_tdata[42:3];
	assign r_hits = m_tdata[82:43];
	assign r_miss = m_tdata[122:83];

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a hit never evicts
	a_hit_evd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(r_hit && r_evd))
		else $error("hit with dirty eviction");

	// dirty eviction only in write-back, write-through only outside it
	a_evd_wt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(r_evd && r_wt))
		else $error("eviction and write-through together");

	// every access is a hit or a miss until the request count saturates
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (r_req != '1) |->
			({1'b0, r_req} == ({1'b0, r_hits} + {1'b0, r_miss})))
		else $error("hit and miss counts do not add up");

endmodule

bind set_assoc_lru_cache_controller salc_checker u_salc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

// ===== dv/tb.sv =====
// Self-checking testbench for the set-associative LRU cache controller.
`timescale 1ns / 100ps

// Expected result of one access
typedef struct {
	bit        hit;
	bit        evd;
	bit        wt;
	bit [39:0] reqs;
	bit [39:0] hits;
	bit [39:0] misses;
	bit [47:0] fetched;
	bit [47:0] written;
} access_result_t;

// Cache state predictor and store of pending results
class cache_scoreboard;
	bit        valid [16384];
	bit        dirty [16384];
	bit [29:0] tags  [16384];
	bit [3:0]  ages  [16384];
	bit [39:0] reqs, hits, misses;
	bit [47:0] fetched, written;
	bit [3:0]  blk_sh = 4'd2;
	bit [3:0]  set_sh = 4'd0;
	bit [4:0]  n_ways = 5'd1;
	bit        wb_mode = 1'b1;
	access_result_t pending [$];
	int errors = 0;

	function void set_reg(salc_pkg::cfg_reg_t idx, bit [4:0] val);
		case (idx)
			salc_pkg::CFG_BLOCK_SHIFT: blk_sh = val[3:0];
			salc_pkg::CFG_SET_SHIFT:   set_sh = val[3:0];
			salc_pkg::CFG_WAYS_USED:   n_ways = val;
			salc_pkg::CFG_WRITE_BACK:  wb_mode = val[0];
		endcase
	endfunction

	function bit [47:0] sat(bit [47:0] a, bit [47:0] b, bit [47:0] lim);
		if (a >= lim || b > lim - a) return lim;
		return a + b;
	endfunction

	// Make a line most recent; valid lines ranked below its old rank age by one
	function void promote(int base, int ways, int used, int old);
		for (int w = 0; w < ways; w++)
			if (w != used && valid[base+w] && ages[base+w] < old && ages[base+w] < 15)
				ages[base+w]++;
		ages[base+used] = 0;
	endfunction

	// Predict the result of one accepted access
	function void note(bit wr, bit [31:0] addr);
		access_result_t r;
		int bs, ss, ways, base, victim, old, i;
		bit [31:0] blk;
		bit [29:0] tg;
		bit [47:0] bsize;
		bs = blk_sh < 2 ? 2 : (blk_sh > 8 ? 8 : blk_sh);
		ss = set_sh > 10 ? 10 : set_sh;
		ways = n_ways == 0 ? 1 : (n_ways > 16 ? 16 : n_ways);
		bsize = 48'd1 << bs;
		blk = addr >> bs;
		base = int'(blk & ((32'd1 << ss) - 1)) * 16;
		tg = 30'(blk >> ss);
		r.hit = 0; r.evd = 0; r.wt = 0;
		reqs = 40'(sat(48'(reqs), 48'd1, 48'hFF_FFFF_FFFF));
		for (int w = 0; w < ways; w++) begin
			if (valid[base+w] && tags[base+w] == tg) begin
				r.hit = 1;
				hits = 40'(sat(48'(hits), 48'd1, 48'hFF_FFFF_FFFF));
				promote(base, ways, w, ages[base+w]);
				if (wr) begin
					if (wb_mode) dirty[base+w] = 1;
					else begin
						r.wt = 1;
						written = sat(written, bsize, 48'hFFFF_FFFF_FFFF);
					end
				end
				break;
			end
		end
		if (!r.hit) begin
			misses = 40'(sat(48'(misses), 48'd1, 48'hFF_FFFF_FFFF));
			fetched = sat(fetched, bsize, 48'hFFFF_FFFF_FFFF);
			victim = ways;
			for (int w = 0; w < ways; w++)
				if (!valid[base+w]) begin
					victim = w;
					break;
				end
			if (victim < ways) old = 16;
			else begin
				victim = 0;
				for (int w = 1; w < ways; w++)
					if (ages[base+w] > ages[base+victim]) victim = w;
				old = ages[base+victim];
				if (dirty[base+victim] && wb_mode) begin
					r.evd = 1;
					written = sat(written, bsize, 48'hFFFF_FFFF_FFFF);
				end
			end
			i = base + victim;
			valid[i] = 1;
			tags[i] = tg;
			dirty[i] = wr && wb_mode;
			promote(base, ways, victim, old);
			if (wr && !wb_mode) begin
				r.wt = 1;
				written = sat(written, bsize, 48'hFFFF_FFFF_FFFF);
			end
		end
		r.reqs = reqs; r.hits = hits; r.misses = misses;
		r.fetched = fetched; r.written = written;
		pending.push_back(r);
	endfunction

	function void field(string name, bit [47:0] exp_v, bit [47:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endfunction

	// Compare one delivered result with the oldest prediction
	function void check(logic [223:0] d);
		access_result_t e;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t unexpected result: expected none actual %0h", $time, d);
			return;
		end
		e = pending.pop_front();
		field("hit", 48'(e.hit), 48'(d[0]));
		field("evicted_dirty", 48'(e.evd), 48'(d[1]));
		field("wrote_through", 48'(e.wt), 48'(d[2]));
		field("request_count", 48'(e.reqs), 48'(d[42:3]));
		field("hit_count", 48'(e.hits), 48'(d[82:43]));
		field("miss_count", 48'(e.misses), 48'(d[122:83]));
		field("bytes_fetched", e.fetched, d[170:123]);
		field("bytes_written", e.written, d[218:171]);
		field("zero_fill", 48'd0, 48'(d[223:219]));
	endfunction
endclass

module tb;
	import salc_pkg::*;

	logic             clk = 0;
	logic             arst_n = 0;
	logic             cfg_we = 0;
	logic [1:0]       cfg_index = 0;
	logic [CFG_W-1:0] cfg_data = 0;
	logic             s_tvalid = 0;
	logic             s_tready;
	logic [31:0]      s_tdata = 0;   // address
	logic             s_tuser = 0;   // access kind: 0 read, 1 write
	logic             m_tvalid;
	logic             m_tready = 0;
	// hit, evicted_dirty, wrote_through, counters from bit 3 up, zero fill
	logic [OUT_W-1:0] m_tdata;

	cache_scoreboard sb = new();
	int  sent = 0;
	int  cycles = 0;
	bit  calm = 0;
	bit  held = 0;
	bit [31:0] pool [64];
	int  pool_n;

	set_assoc_lru_cache_controller dut (.*);

	always #10 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result checking, sampled mid-cycle
	always @(negedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check(m_tdata);

	// Receiver: random stall bursts, one long hold-off, none near the end
	initial begin
		int n;
		@(posedge clk);
		forever begin
			if (!held && sent > 400) begin
				held = 1;
				m_tready <= 0;
				repeat (300) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 5);
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end else begin
				m_tready <= 1;
				@(posedge clk);
			end
		end
	end

	task automatic cfg_write(cfg_reg_t idx, bit [4:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// Wait for the block to drain, then write all registers
	task automatic configure(bit [3:0] bs, bit [3:0] ss, bit [4:0] ways, bit wb);
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_write(CFG_BLOCK_SHIFT, 5'(bs));
		cfg_write(CFG_SET_SHIFT, 5'(ss));
		cfg_write(CFG_WAYS_USED, ways);
		cfg_write(CFG_WRITE_BACK, 5'(wb));
	endtask

	task automatic send(bit wr, bit [31:0] addr);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 5);
			s_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= addr;
		s_tuser <= wr;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		sb.note(wr, addr);
		sent++;
	endtask

	task automatic new_pool();
		bit [31:0] common;
		pool_n = $urandom_range(3, 48);
		common = $urandom();
		for (int i = 0; i < pool_n; i++) begin
			pool[i] = $urandom();
			if ($urandom_range(0, 1)) pool[i][17:0] = common[17:0];
		end
	endtask

	task automatic random_access();
		bit [31:0] a;
		if ($urandom_range(0, 99) < 85) begin
			a = pool[$urandom_range(0, pool_n - 1)];
			a[7:0] = 8'($urandom());
		end else a = $urandom();
		send(1'($urandom_range(0, 1)), a);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset settings: one way, one set, write-back; dirty eviction
		send(0, 32'h0000_0000);
		send(1, 32'h0000_0003);
		send(1, 32'hFFFF_FFFF);
		send(0, 32'h0000_0000);
		send(0, 32'h0000_0000);
		// Largest geometry, write-through hits and misses
		configure(4'd8, 4'd10, 5'd16, 1'b0);
		send(1, 32'h1234_5678);
		send(1, 32'h1234_5600);
		send(0, 32'hFFFF_FFFF);
		send(1, 32'h0000_0000);
		// Out-of-range registers: block shift low, set shift large, zero ways
		configure(4'd0, 4'd15, 5'd0, 1'b1);
		send(1, 32'hAAAA_AAAA);
		send(1, 32'h5555_5555);
		send(0, 32'hAAAA_AAAA);
		// Block shift above range, ways above range; LRU victim with full set
		configure(4'd15, 4'd0, 5'd31, 1'b1);
		for (int i = 0; i < 17; i++) send(i[0], {i[7:0], 24'h0});
		send(0, 32'h0100_0000);
		// Config change with stored lines kept: fewer ways, write-through
		configure(4'd8, 4'd0, 5'd4, 1'b0);
		send(1, 32'h0000_0000);
		send(0, 32'h0500_0000);

		// Random phases; no reconfiguration once the closing stretch starts
		while (sent < 1780) begin
			if (!calm) begin
				if ($urandom_range(0, 3) == 0)
					configure(4'($urandom()), 4'($urandom()), 5'($urandom()),
						1'($urandom()));
				else
					configure(4'($urandom_range(2, 8)), 4'($urandom_range(0, 10)),
						5'($urandom_range(1, 16)), 1'($urandom()));
			end
			new_pool();
			for (int i = 0; i < 150 && sent < 1780; i++) begin
				if (sent > 1550) calm = 1;
				random_access();
			end
		end

		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== files.f =====
hdl/salc_pkg.sv
hdl/salc_front.sv
hdl/salc_back.sv
hdl/set_assoc_lru_cache_controller.sv
hdl/salc_checker.sv
dv/tb.sv
